@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the chord matcher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define KCCM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("key cluster chord matcher check failed");

// Checked at every rising edge, reset included.
`define KCCM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("key cluster chord matcher check failed");

`endif

@@ hdl/kccm_pkg.sv @@
// ----------------------------------------------------------------------------
// kccm_pkg
// Types and constants shared by the chord matcher and its member cells.
// ----------------------------------------------------------------------------
package kccm_pkg;

	localparam int KEY_W = 8;
	localparam int IDS_W = 64;
	localparam int COUNT_REG_W = 4;
	localparam int CNT_W = 5;
	localparam int REG_IDX_W = 2;
	localparam int WR_DATA_W = 64;

	localparam logic [REG_IDX_W-1:0] REG_MEMBER_IDS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MEMBER_COUNT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FORBID_RELEASE = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PEDANTIC_MODE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_ACTIVATING = 3'd1,
		ST_MATCHES = 3'd2,
		ST_FINALIZED = 3'd3,
		ST_DEACTIVATING = 3'd4,
		ST_INVALID = 3'd5
	} state_t;

	// Carried from cell to cell: whether an earlier member matched the key,
	// and the held bit of the first member that did.
	typedef struct packed {
		logic found;
		logic first_held;
	} link_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic press;
	} cell_ctrl_t;

	typedef struct packed {
		logic held;
		logic ever;
		logic held_nx;
		logic ever_nx;
	} cell_stat_t;

endpackage

@@ hdl/kccm_cell.sv @@
// ----------------------------------------------------------------------------
// kccm_cell
// One cluster member: compares its id with the key, holds its held and
// ever-pressed bits, and passes the first-match link to the next cell.
// ----------------------------------------------------------------------------
module kccm_cell #(
	parameter int ID_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [kccm_pkg::KEY_W-1:0]  key,
	input  logic [ID_BITS-1:0]          mem_id,
	input  logic                        active,
	input  kccm_pkg::cell_ctrl_t        ctrl,
	input  kccm_pkg::link_t             link_in,
	output kccm_pkg::link_t             link_out,
	output kccm_pkg::cell_stat_t        stat
);

	localparam int CMP_W = (ID_BITS > kccm_pkg::KEY_W) ? ID_BITS : kccm_pkg::KEY_W;

	logic [CMP_W-1:0] key_ext;
	logic [CMP_W-1:0] id_ext;
	logic             hit;
	logic             first;
	logic             held_q;
	logic             ever_q;
	logic             held_nx;
	logic             ever_nx;

	assign key_ext = CMP_W'(key);
	assign id_ext  = CMP_W'(mem_id);
	assign hit     = active && (key_ext == id_ext);
	assign first   = hit && !link_in.found;

	assign link_out.found      = link_in.found | hit;
	assign link_out.first_held = link_in.found ? link_in.first_held : (hit & held_q);

	assign held_nx = ctrl.press ? (held_q | hit) : (held_q & ~first);
	assign ever_nx = ever_q | (ctrl.press & hit);

	assign stat.held    = held_q;
	assign stat.ever    = ever_q;
	assign stat.held_nx = held_nx;
	assign stat.ever_nx = ever_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			ever_q <= 1'b0;
		end else if (ctrl.clr) begin
			held_q <= 1'b0;
			ever_q <= 1'b0;
		end else if (ctrl.upd) begin
			held_q <= held_nx;
			ever_q <= ever_nx;
		end
	end

endmodule

@@ hdl/key_cluster_chord_matcher.sv @@
// ----------------------------------------------------------------------------
// key_cluster_chord_matcher: one event per cycle while in_ready is high.
// Cells match combinationally; the result shows in the cycle after the accept.
// Reset clears the member masks, the match state and the result register.
// ----------------------------------------------------------------------------
module key_cluster_chord_matcher #(
	parameter int MAX_MEMBERS = 8,
	parameter int ID_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [kccm_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [kccm_pkg::WR_DATA_W-1:0]    wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [kccm_pkg::KEY_W-1:0]        key_id,
	input  logic                              pressed,
	input  logic                              probe_only,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              consumed,
	output logic [2:0]                        match_state
);

	`include "assert_macros.svh"

	logic [kccm_pkg::IDS_W-1:0]         member_ids_q;
	logic [kccm_pkg::COUNT_REG_W-1:0]   member_count_q;
	logic                               forbid_release_q;
	logic                               pedantic_mode_q;

	logic [kccm_pkg::IDS_W+ID_BITS-1:0] ids_ext;
	logic [ID_BITS-1:0]                 mem_id [MAX_MEMBERS];
	logic [kccm_pkg::CNT_W-1:0]         n_eff;
	kccm_pkg::link_t                    links [MAX_MEMBERS+1];
	kccm_pkg::cell_stat_t               stat [MAX_MEMBERS];
	kccm_pkg::cell_ctrl_t               ctrl;
	logic [MAX_MEMBERS-1:0]             held_vec;
	logic [MAX_MEMBERS-1:0]             ever_vec;
	logic [kccm_pkg::CNT_W-1:0]         held_cnt;
	logic [kccm_pkg::CNT_W-1:0]         pressed_cnt;

	logic                               accept;
	logic                               release_ok;
	kccm_pkg::state_t                   state_q;
	kccm_pkg::state_t                   state_d;
	logic                               all_seen_q;
	logic                               all_seen_d;
	logic                               consumed_d;
	logic                               out_valid_q;
	logic                               consumed_q;
	kccm_pkg::state_t                   match_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_ids_q     <= '0;
			member_count_q   <= kccm_pkg::COUNT_REG_W'(1);
			forbid_release_q <= 1'b0;
			pedantic_mode_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				kccm_pkg::REG_MEMBER_IDS:     member_ids_q <= wr_data;
				kccm_pkg::REG_MEMBER_COUNT:   member_count_q <= wr_data[kccm_pkg::COUNT_REG_W-1:0];
				kccm_pkg::REG_FORBID_RELEASE: forbid_release_q <= wr_data[0];
				kccm_pkg::REG_PEDANTIC_MODE:  pedantic_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign ids_ext = {{ID_BITS{1'b0}}, member_ids_q};

	always_comb begin
		n_eff = (member_count_q == '0) ? kccm_pkg::CNT_W'(1)
			: kccm_pkg::CNT_W'(member_count_q);
		if (n_eff > kccm_pkg::CNT_W'(MAX_MEMBERS)) begin
			n_eff = kccm_pkg::CNT_W'(MAX_MEMBERS);
		end
	end

	assign accept     = in_valid && in_ready;
	assign in_ready   = !out_valid_q || out_ready;
	assign release_ok = !forbid_release_q && links[MAX_MEMBERS].first_held;

	assign ctrl.clr   = accept && cmd;
	assign ctrl.upd   = accept && !cmd && (pressed || release_ok);
	assign ctrl.press = pressed;

	assign links[0] = '0;

	for (genvar k = 0; k < MAX_MEMBERS; k++) begin : g_cell
		if (ID_BITS * k < kccm_pkg::IDS_W) begin : g_id
			assign mem_id[k] = ids_ext[ID_BITS*k +: ID_BITS];
		end else begin : g_zero
			assign mem_id[k] = '0;
		end

		kccm_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (key_id),
			.mem_id  (mem_id[k]),
			.active  (kccm_pkg::CNT_W'(k) < n_eff),
			.ctrl    (ctrl),
			.link_in (links[k]),
			.link_out(links[k+1]),
			.stat    (stat[k])
		);

		assign held_vec[k] = stat[k].held;
		assign ever_vec[k] = stat[k].ever;
	end

	always_comb begin
		held_cnt    = '0;
		pressed_cnt = '0;
		for (int i = 0; i < MAX_MEMBERS; i++) begin
			held_cnt    = held_cnt + kccm_pkg::CNT_W'(stat[i].held_nx);
			pressed_cnt = pressed_cnt + kccm_pkg::CNT_W'(stat[i].ever_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kccm_pkg::ST_IDLE;
			all_seen_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			all_seen_q <= all_seen_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		all_seen_d = all_seen_q;
		consumed_d = 1'b0;
		if (accept) begin
			if (cmd) begin
				state_d    = kccm_pkg::ST_IDLE;
				all_seen_d = 1'b0;
			end else if (!links[MAX_MEMBERS].found) begin
				if (pressed && !probe_only) begin
					state_d = kccm_pkg::ST_INVALID;
				end
			end else if (!pressed && forbid_release_q) begin
				if (!probe_only) begin
					state_d = kccm_pkg::ST_INVALID;
				end
			end else if (pressed || release_ok) begin
				consumed_d = 1'b1;
				if (held_cnt == '0 && all_seen_q) begin
					state_d = pedantic_mode_q ? kccm_pkg::ST_MATCHES : kccm_pkg::ST_FINALIZED;
				end else if (pressed_cnt == n_eff) begin
					all_seen_d = 1'b1;
					state_d    = kccm_pkg::ST_MATCHES;
				end else if (all_seen_q) begin
					state_d = kccm_pkg::ST_DEACTIVATING;
				end else begin
					state_d = kccm_pkg::ST_ACTIVATING;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumed_q    <= 1'b0;
			match_state_q <= kccm_pkg::ST_IDLE;
		end else if (accept) begin
			consumed_q    <= consumed_d;
			match_state_q <= state_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign consumed    = consumed_q;
	assign match_state = match_state_q;

	`KCCM_ASSERT_ALWAYS(a_held_within_ever, clk, (held_vec & ~ever_vec) == '0)

	`KCCM_ASSERT(a_consumed_state, clk, arst_n,
		out_valid && consumed |-> match_state != kccm_pkg::ST_IDLE
			&& match_state != kccm_pkg::ST_INVALID)

	`KCCM_ASSERT(a_reset_cmd_result, clk, arst_n,
		in_valid && in_ready && cmd |=> out_valid && !consumed
			&& match_state == kccm_pkg::ST_IDLE && held_vec == '0)

endmodule
